/* hdl/swco_pkg.sv */
// swco_pkg: payload structs, scan control struct and fixed widths for the
// sliding window clock offset unit. No dependencies.
`default_nettype none

package swco_pkg;

    localparam int TIME_W = 63;
    localparam int DIFF_W = 64;
    localparam int CFG_W  = 7;
    localparam int FILL_W = 7;

    localparam logic [CFG_W-1:0] WIN_RESET = 7'd64;

    typedef struct packed {
        logic [TIME_W-1:0] local_time;
        logic [TIME_W-1:0] remote_time;
    } t_swco_in;

    typedef struct packed {
        logic signed [DIFF_W-1:0] offset_estimate;
        logic [DIFF_W-1:0]        jitter_spread;
        logic [FILL_W-1:0]        fill_level;
    } t_swco_out;

    // one read beat of the window scan
    typedef struct packed {
        logic vld;
        logic first;
    } t_scan_ctl;

endpackage

`default_nettype wire

/* hdl/swco_ring.sv */
// swco_ring: difference ring storage, one write port and one registered
// read port. Uses swco_pkg for the data width.
`default_nettype none

module swco_ring
    import swco_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DIFF_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DIFF_W-1:0] o_rdata
);

    logic [DIFF_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/swco_minmax.sv */
// swco_minmax: running signed minimum and maximum over the scanned window
// entries, one entry per cycle. Uses swco_pkg for t_scan_ctl and widths.
`default_nettype none

module swco_minmax
    import swco_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_scan_ctl         i_ctl,
    input  wire logic [DIFF_W-1:0] i_data,
    output logic      [DIFF_W-1:0] o_lo,
    output logic      [DIFF_W-1:0] o_hi
);

    logic lt_lo;
    logic gt_hi;

    assign lt_lo = $signed(i_data) < $signed(o_lo);
    assign gt_hi = $signed(i_data) > $signed(o_hi);

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            if (i_ctl.first || lt_lo) begin
                o_lo <= i_data;
            end
            if (i_ctl.first || gt_hi) begin
                o_hi <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/sliding_window_clock_offset_unit.sv */
// sliding_window_clock_offset_unit: top level with the sequencer and the
// shared 64-bit subtractor. Uses swco_pkg, swco_ring and swco_minmax.
//
// Usage: an observation (local_time, remote_time) transfers on the input
// channel when i_in_valid is high and o_in_stall is low. The block keeps the
// differences local minus remote in a ring of the last window_size entries
// and returns one result per observation on the output channel (o_out_valid,
// i_out_stall): the signed minimum difference, the spread max minus min, and
// the number of entries held.
// The sequencer writes the new difference into the ring, scans the entries
// held, forms the spread and then loads the result into the output
// register. The scan reads one ring entry per cycle through the single
// memory read port; the same subtractor forms the difference and the spread.
// o_in_stall is high from the input transfer until the result is loaded into
// the output register; a new observation is taken while that result waits.
// If the receiver stalls, the result holds and the sequencer waits before
// loading the next one. Reset leaves an empty window of size 64. A write on
// i_cfg_we sets window_size and empties the window; write it only when idle.
`default_nettype none

module sliding_window_clock_offset_unit
    import swco_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_swco_in         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_swco_out             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SCAN,
        S_DRAIN,
        S_SPREAD
    } t_state;

    t_state            r_state, n_state;
    t_swco_in          r_in, n_in;
    logic [CFG_W-1:0]  r_win, n_win;
    logic [AW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_held, n_held;
    logic [CW-1:0]     r_idx, n_idx;
    t_scan_ctl         r_rd_ctl, n_rd_ctl;
    t_swco_out         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [WW-1:0]     win_ext;
    logic [WW-1:0]     eff_ext;
    logic [CW-1:0]     eff;
    logic [AW-1:0]     wr_slot;
    logic [CW-1:0]     slot_inc;
    logic              ring_we;
    logic              ring_re;
    logic [DIFF_W-1:0] ring_rdata;
    logic [DIFF_W-1:0] lo;
    logic [DIFF_W-1:0] hi;
    logic [DIFF_W-1:0] sub_a;
    logic [DIFF_W-1:0] sub_b;
    logic [DIFF_W-1:0] sub_y;
    logic              out_free;

    // window size clamped to 1..MAX_WINDOW
    assign win_ext = WW'(r_win);
    assign eff_ext = (win_ext == '0) ? WW'(1)
                   : (win_ext > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : win_ext;
    assign eff     = CW'(eff_ext);

    assign wr_slot  = (CW'(r_slot) >= eff) ? '0 : r_slot;
    assign slot_inc = CW'(wr_slot) + CW'(1);

    // shared subtractor: difference first, spread at the end
    assign sub_a = (r_state == S_SPREAD) ? hi : {1'b0, r_in.local_time};
    assign sub_b = (r_state == S_SPREAD) ? lo : {1'b0, r_in.remote_time};
    assign sub_y = sub_a - sub_b;

    assign ring_we  = (r_state == S_DIFF);
    assign ring_re  = (r_state == S_SCAN);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_win       = r_win;
        n_slot      = r_slot;
        n_held      = r_held;
        n_idx       = r_idx;
        n_rd_ctl    = '0;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_win  = i_cfg_data;
                    n_slot = '0;
                    n_held = '0;
                end
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_slot  = (slot_inc >= eff) ? '0 : AW'(slot_inc);
                n_held  = (r_held < eff) ? r_held + CW'(1) : eff;
                n_idx   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_rd_ctl.vld   = 1'b1;
                n_rd_ctl.first = (r_idx == '0);
                n_idx          = r_idx + CW'(1);
                if (r_idx == r_held - CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SPREAD;
            end
            S_SPREAD: begin
                if (out_free) begin
                    n_out.offset_estimate = lo;
                    n_out.jitter_spread   = sub_y;
                    n_out.fill_level      = FILL_W'(r_held);
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WIN_RESET;
            r_slot      <= '0;
            r_held      <= '0;
            r_idx       <= '0;
            r_rd_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win       <= n_win;
            r_slot      <= n_slot;
            r_held      <= n_held;
            r_idx       <= n_idx;
            r_rd_ctl    <= n_rd_ctl;
            r_out_valid <= n_out_valid;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

    swco_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (wr_slot),
        .i_wdata (sub_y),
        .i_re    (ring_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ring_rdata)
    );

    swco_minmax u_minmax (
        .i_clk  (i_clk),
        .i_ctl  (r_rd_ctl),
        .i_data (ring_rdata),
        .o_lo   (lo),
        .o_hi   (hi)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
